>>> rtl/hmc_pkg.sv
// Shared types and constants for the HTTP message completeness check.
package hmc_pkg;

	localparam int KEY_LEN  = 15;
	localparam int TERM_LEN = 4;

	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	// "Content-Length:" one byte per entry, first character at index 0
	localparam logic [7:0] KEYWORD [KEY_LEN] = '{
		8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
		8'h4c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a
	};

	typedef enum logic [1:0] {
		ST_MORE      = 2'd0,
		ST_COMPLETE  = 2'd1,
		ST_MALFORMED = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_NONE   = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_CLOSED = 4'b1000
	} phase_t;

endpackage

>>> rtl/hmc_in_if.sv
// Input channel: one request byte per item.
interface hmc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

>>> rtl/hmc_out_if.sv
// Output channel: one framing status per item.
interface hmc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        length_found;
	logic [31:0] body_offset;

	modport source (output valid, output status, output length_found, output body_offset,
		input ready);
	modport sink   (input valid, input status, input length_found, input body_offset,
		output ready);
endinterface

>>> rtl/http_message_completeness_check_unit.sv
// Top level: HTTP message completeness check with Content-Length framing.
// Each accepted byte's result is registered in the output register at the edge that accepts it.
// Throughput: one byte per cycle while the result side is ready; the output register accepts a new byte while
// its held result is taken in the same cycle.
// Reset: arst_n clears all match, length and count state and empties the
// output register; a byte with first_byte set clears the state as well.
module http_message_completeness_check_unit
	import hmc_pkg::*;
#(
	parameter int COUNT_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	hmc_in_if.sink    req,
	hmc_out_if.source res
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// Framing state
	logic [COUNT_BITS-1:0] byte_count_q;
	logic [2:0]            term_prog_q;
	logic                  headers_done_q;
	logic [3:0]            key_prog_q;
	phase_t                phase_q;
	logic [COUNT_BITS-1:0] length_q;
	logic                  length_err_q;
	logic [COUNT_BITS-1:0] body_start_q;
	logic [COUNT_BITS-1:0] body_end_q;

	// Output register
	logic       out_valid_q;
	status_t    status_q;
	logic       found_q;
	logic [31:0] offset_q;

	// State as seen by this item: a first byte starts from a cleared state
	logic [COUNT_BITS-1:0] cur_count;
	logic [2:0]            cur_term;
	logic                  cur_done;
	logic [3:0]            cur_key;
	phase_t                cur_phase;
	logic [COUNT_BITS-1:0] cur_len;
	logic                  cur_err;

	logic [COUNT_BITS-1:0] count_nx;
	logic [2:0]            term_nx;
	logic                  done_nx;
	logic                  term_hit;
	logic [3:0]            key_nx;
	phase_t                phase_nx;
	logic [COUNT_BITS-1:0] len_nx;
	logic                  err_nx;
	logic [COUNT_BITS-1:0] start_nx;
	logic [COUNT_BITS-1:0] end_nx;
	status_t               status_nx;

	logic                  is_digit;
	logic                  is_blank;
	logic [COUNT_BITS-1:0] digit_val;
	logic [COUNT_BITS+3:0] len_times10;
	logic [COUNT_BITS:0]   end_sum;
	logic [COUNT_BITS+31:0] offset_ext;
	logic [7:0]            b;
	logic                  take;

	assign b    = req.data_byte;
	assign take = req.valid && req.ready;

	// Accept while the output register is empty or is being drained
	assign req.ready = !out_valid_q || res.ready;

	assign res.valid        = out_valid_q;
	assign res.status       = status_q;
	assign res.length_found = found_q;
	assign res.body_offset  = offset_q;

	always_comb begin
		if (req.first_byte) begin
			cur_count = '0;
			cur_term  = '0;
			cur_done  = 1'b0;
			cur_key   = '0;
			cur_phase = PH_NONE;
			cur_len   = '0;
			cur_err   = 1'b0;
		end else begin
			cur_count = byte_count_q;
			cur_term  = term_prog_q;
			cur_done  = headers_done_q;
			cur_key   = key_prog_q;
			cur_phase = phase_q;
			cur_len   = length_q;
			cur_err   = length_err_q;
		end
	end

	assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	assign is_blank  = (b == CHAR_SPACE) || (b == CHAR_TAB);
	assign digit_val = COUNT_BITS'(b - CHAR_ZERO);
	// length * 10 + digit, wide enough to detect saturation
	assign len_times10 = ({1'b0, cur_len, 3'b000} + {3'b000, cur_len, 1'b0})
		+ (COUNT_BITS+4)'(digit_val);

	// Saturating byte counter
	assign count_nx = (cur_count == CNT_MAX) ? CNT_MAX : cur_count + COUNT_BITS'(1);

	// Header terminator match
	always_comb begin
		term_nx = cur_term;
		if (!cur_done) begin
			case (cur_term)
				3'd0: term_nx = (b == CHAR_CR) ? 3'd1 : 3'd0;
				3'd1: term_nx = (b == CHAR_LF) ? 3'd2 : ((b == CHAR_CR) ? 3'd1 : 3'd0);
				3'd2: term_nx = (b == CHAR_CR) ? 3'd3 : 3'd0;
				3'd3: term_nx = (b == CHAR_LF) ? 3'(TERM_LEN)
					: ((b == CHAR_CR) ? 3'd1 : 3'd0);
				default: term_nx = 3'd0;
			endcase
		end
	end

	assign term_hit = !cur_done && (term_nx == 3'(TERM_LEN));
	assign done_nx  = cur_done || term_hit;
	assign start_nx = term_hit ? count_nx : body_start_q;

	// Keyword search and length decode, only ahead of the terminator
	always_comb begin
		key_nx   = cur_key;
		phase_nx = cur_phase;
		len_nx   = cur_len;
		err_nx   = cur_err;
		if (!cur_done) begin
			case (cur_phase)
				PH_NONE: begin
					if (cur_key < 4'(KEY_LEN) && b == KEYWORD[cur_key])
						key_nx = cur_key + 4'd1;
					else
						key_nx = (b == KEYWORD[0]) ? 4'd1 : 4'd0;
					if (key_nx == 4'(KEY_LEN))
						phase_nx = PH_SKIP;
				end
				PH_SKIP: begin
					if (is_digit) begin
						len_nx   = digit_val;
						phase_nx = PH_DIGITS;
					end else if (!is_blank) begin
						err_nx   = 1'b1;
						phase_nx = PH_CLOSED;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						// saturate at the counter maximum
						if (len_times10[COUNT_BITS+3:COUNT_BITS] != 4'd0)
							len_nx = CNT_MAX;
						else
							len_nx = len_times10[COUNT_BITS-1:0];
					end else begin
						phase_nx = PH_CLOSED;
					end
				end
				PH_CLOSED: ;
				default: phase_nx = cur_phase;
			endcase
		end
	end

	// Body end: the terminator byte is never a digit, so the length is final here
	assign end_sum = {1'b0, count_nx} + {1'b0, cur_len};
	assign end_nx  = term_hit ? (end_sum[COUNT_BITS] ? CNT_MAX : end_sum[COUNT_BITS-1:0])
		: body_end_q;

	always_comb begin
		status_nx = ST_MORE;
		if (done_nx) begin
			if (phase_nx == PH_NONE)
				status_nx = ST_COMPLETE;
			else if (err_nx)
				status_nx = ST_MALFORMED;
			else if (term_hit) begin
				// count equals body start: done only for an empty body or a full counter
				if (cur_len == '0 || count_nx == CNT_MAX)
					status_nx = ST_COMPLETE;
			end else if (count_nx >= body_end_q)
				status_nx = ST_COMPLETE;
		end
	end

	assign offset_ext = {32'd0, start_nx};

	// Advance framing state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			term_prog_q    <= '0;
			headers_done_q <= 1'b0;
			key_prog_q     <= '0;
			phase_q        <= PH_NONE;
			length_q       <= '0;
			length_err_q   <= 1'b0;
			body_start_q   <= '0;
			body_end_q     <= '0;
		end else if (take) begin
			byte_count_q   <= count_nx;
			term_prog_q    <= term_nx;
			headers_done_q <= done_nx;
			key_prog_q     <= key_nx;
			phase_q        <= phase_nx;
			length_q       <= len_nx;
			length_err_q   <= err_nx;
			body_start_q   <= req.first_byte ? start_nx & {COUNT_BITS{term_hit}} : start_nx;
			body_end_q     <= end_nx;
		end
	end

	// Output register: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_nx;
			found_q  <= (phase_nx != PH_NONE);
			offset_q <= done_nx ? offset_ext[31:0] : 32'd0;
		end
	end

endmodule

>>> test/http_message_completeness_check_unit_tb.sv
// Testbench for the HTTP message completeness check: byte stream in, framing status out.
module http_message_completeness_check_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hmc_pkg::*;

	localparam logic [63:0] COUNT_MAX    = 64'h0000_0000_FFFF_FFFF;
	localparam int          RANDOM_BYTES = 1600;
	// last stretch of the random traffic runs without any idling
	localparam int          CALM_BYTES   = 250;
	// cycles without any handshake before the run is declared hung
	localparam int          QUIET_LIMIT  = 200;

	typedef struct packed {
		status_t     status;
		logic        length_found;
		logic [31:0] body_offset;
	} framing_t;

	logic clk;
	logic arst_n;

	hmc_in_if  req();
	hmc_out_if res();

	http_message_completeness_check_unit #(.COUNT_BITS(32)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	// Framing predictor state: a private copy of what the block tracks.
	logic [63:0] seen_bytes;
	int          crlf_run;
	bit          header_end_seen;
	int          key_run;
	phase_t      len_phase;
	logic [63:0] len_value;
	bit          len_bad;
	logic [63:0] body_at;

	framing_t    expected_frames [$];
	logic [7:0]  msg_bytes [$];

	int mismatches;
	int bytes_sent;
	int quiet_cycles;
	bit calm;
	// 0 means never idle; otherwise an idle burst starts with odds 1 in N
	int gap_odds;
	int stall_odds;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
		if (a > COUNT_MAX || b > COUNT_MAX - a)
			return COUNT_MAX;
		return a + b;
	endfunction

	function automatic void clear_framing();
		seen_bytes      = '0;
		crlf_run        = 0;
		header_end_seen = 1'b0;
		key_run         = 0;
		len_phase       = PH_NONE;
		len_value       = '0;
		len_bad         = 1'b0;
		body_at         = '0;
	endfunction

	// Advance the predictor by one byte and return the framing it should report.
	function automatic framing_t frame_step(input logic [7:0] b, input bit first);
		framing_t    r;
		logic [63:0] d;
		bit          digit;
		digit = b >= CHAR_ZERO && b <= CHAR_NINE;
		d = 64'(b) - 64'(CHAR_ZERO);
		if (first)
			clear_framing();
		seen_bytes = sat_sum(seen_bytes, 64'd1);
		if (!header_end_seen) begin
			case (len_phase)
				PH_SKIP: begin
					// blanks are skipped; anything else opens or spoils the value
					if (b != CHAR_SPACE && b != CHAR_TAB) begin
						if (digit) begin
							len_value = d;
							len_phase = PH_DIGITS;
						end else begin
							len_bad   = 1'b1;
							len_phase = PH_CLOSED;
						end
					end
				end
				PH_DIGITS: begin
					if (!digit)
						len_phase = PH_CLOSED;
					else if (len_value > (COUNT_MAX - d) / 10)
						len_value = COUNT_MAX;
					else
						len_value = len_value * 10 + d;
				end
				PH_NONE: begin
					if (key_run < KEY_LEN && b == KEYWORD[key_run])
						key_run++;
					else
						key_run = (b == KEYWORD[0]) ? 1 : 0;
					if (key_run == KEY_LEN)
						len_phase = PH_SKIP;
				end
				default: ;
			endcase
			case (crlf_run)
				0:       crlf_run = (b == CHAR_CR) ? 1 : 0;
				1:       crlf_run = (b == CHAR_LF) ? 2 : ((b == CHAR_CR) ? 1 : 0);
				2:       crlf_run = (b == CHAR_CR) ? 3 : 0;
				3:       crlf_run = (b == CHAR_LF) ? 4 : ((b == CHAR_CR) ? 1 : 0);
				default: crlf_run = 0;
			endcase
			if (crlf_run == TERM_LEN) begin
				header_end_seen = 1'b1;
				body_at         = seen_bytes;
			end
		end
		r.status = ST_MORE;
		if (header_end_seen) begin
			if (len_phase == PH_NONE)
				r.status = ST_COMPLETE;
			else if (len_bad)
				r.status = ST_MALFORMED;
			else if (seen_bytes >= sat_sum(body_at, len_value))
				r.status = ST_COMPLETE;
		end
		r.length_found = len_phase != PH_NONE;
		r.body_offset  = header_end_seen ? body_at[31:0] : 32'd0;
		return r;
	endfunction

	// Drive one byte at the falling edge, hold it until accepted, then predict its framing.
	task automatic send_byte(input logic [7:0] b, input bit first);
		int idle;
		@(negedge clk);
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			idle = $urandom_range(1, 6);
			req.valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.data_byte  <= b;
		req.first_byte <= first;
		do @(posedge clk); while (!req.ready);
		expected_frames.push_back(frame_step(b, first));
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input bit first);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], first && i == 0);
	endtask

	task automatic send_message(input bit first);
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], first && i == 0);
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endfunction

	// Sink side: stall the result channel in random bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		res.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				stall_left = $urandom_range(1, 6) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Compare every accepted result with the oldest pending prediction.
	always @(posedge clk) begin : check_results
		framing_t want;
		if (res.valid === 1'b1 && res.ready) begin
			if (expected_frames.size() == 0) begin
				$error("result with no byte pending: status %0d", res.status);
				mismatches++;
			end else begin
				want = expected_frames.pop_front();
				if (res.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res.status);
					mismatches++;
				end
				if (res.length_found !== want.length_found) begin
					$error("length_found: expected %0d, got %0d", want.length_found,
						res.length_found);
					mismatches++;
				end
				if (res.body_offset !== want.body_offset) begin
					$error("body_offset: expected %0d, got %0d", want.body_offset,
						res.body_offset);
					mismatches++;
				end
			end
		end
	end

	// Hang detector: count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid === 1'b1 && res.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// The block must run from reset state when first_byte never arrives.
	task automatic test_continued_stream();
		send_text("GET /\015\012\015\012ab", 1'b0);
	endtask

	// Body counted against the length, including a zero length.
	task automatic test_length_framing();
		send_text("Content-Length: 3\015\012\015\012abcde", 1'b1);
		send_text("Content-Length: 0\015\012\015\012q", 1'b1);
	endtask

	// Repeated C restarts the keyword match; tabs and spaces skipped; text after digits dropped.
	task automatic test_blanks_and_trailing_text();
		send_text("CContent-Lengt Content-Length:\t \t12xy\015\012\015\012", 1'b1);
		send_text("0123456789abc", 1'b0);
	endtask

	// A sign, a bare line end or a stray character where the digits should start.
	task automatic test_malformed_length();
		send_text("Content-Length: -4\015\012\015\012z", 1'b1);
		send_text("Content-Length:\015\012\015\012", 1'b1);
		send_text("Content-Length: +\015\012\015\012", 1'b1);
	endtask

	// Length past the counter maximum clamps; the completion sum clamps too.
	task automatic test_saturation();
		send_text("Content-Length: 99999999999\015\012\015\012xy", 1'b1);
		send_text("Content-Length:4294967295\015\012\015\012x", 1'b1);
	endtask

	// Only the first keyword counts, and none after the terminator.
	task automatic test_ignored_keywords();
		send_text("Content-Length: 1\015\012Content-Length: 9\015\012\015\012xy", 1'b1);
		send_text("A\015\012\015\012Content-Length: 5\015\012", 1'b1);
	endtask

	// Extreme byte values and broken terminator runs.
	task automatic test_odd_bytes();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_text("\015\015\012\015\015\012\012\015\012\015\012z", 1'b0);
	endtask

	function automatic void add_filler_line();
		int n;
		n = $urandom_range(1, 8);
		repeat (n) msg_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
		add_text(": ");
		n = $urandom_range(0, 6);
		repeat (n) msg_bytes.push_back(8'($urandom_range(32, 126)));
		add_text("\015\012");
	endfunction

	// Append a Content-Length line; return the short length used, or -1 if none applies.
	function automatic int add_length_line();
		int n;
		int pick;
		int value;
		value = -1;
		add_text("Content-Length:");
		n = $urandom_range(0, 3);
		repeat (n) msg_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 2))
				0:       add_text("-");
				1:       add_text("x");
				default: ;
			endcase
		end else if (pick == 1) begin
			n = $urandom_range(10, 20);
			repeat (n) msg_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
		end else begin
			value = $urandom_range(0, 12);
			if (pick == 2)
				add_text("00");
			add_text($sformatf("%0d", value));
		end
		if ($urandom_range(0, 4) == 0)
			add_text(" ;x");
		add_text("\015\012");
		return value;
	endfunction

	// Mostly well-formed requests with random content; some truncated, some noise.
	task automatic send_random_message();
		int  kind;
		int  body_len;
		int  short_len;
		int  n;
		bit  first;
		msg_bytes.delete();
		first = $urandom_range(0, 9) != 0;
		kind  = $urandom_range(0, 9);
		if (kind == 9) begin
			n = $urandom_range(1, 24);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0:       msg_bytes.push_back(CHAR_CR);
					1:       msg_bytes.push_back(CHAR_LF);
					default: msg_bytes.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			short_len = -1;
			add_text("P /\015\012");
			if ($urandom_range(0, 1)) add_filler_line();
			if ($urandom_range(0, 9) < 7) short_len = add_length_line();
			if ($urandom_range(0, 1)) add_filler_line();
			add_text("\015\012");
			if (short_len >= 0)
				body_len = short_len + $urandom_range(0, 4) - 2;
			else
				body_len = $urandom_range(0, 5);
			if (body_len < 0)
				body_len = 0;
			repeat (body_len) msg_bytes.push_back(8'($urandom_range(0, 255)));
			// broken request: cut anywhere
			if (kind == 8) begin
				n = $urandom_range(1, msg_bytes.size());
				while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
			end
		end
		send_message(first);
	endtask

	task automatic test_random_traffic();
		int start;
		int odds [3] = '{0, 3, 8};
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			// vary the idling per request so some stretches see none at all
			gap_odds   = odds[$urandom_range(0, 2)];
			stall_odds = odds[$urandom_range(0, 2)];
			if (RANDOM_BYTES - (bytes_sent - start) < CALM_BYTES)
				calm = 1'b1;
			send_random_message();
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.data_byte  = '0;
		req.first_byte = 1'b0;
		mismatches     = 0;
		bytes_sent     = 0;
		quiet_cycles   = 0;
		calm           = 1'b0;
		gap_odds       = 4;
		stall_odds     = 4;
		clear_framing();

		// hold reset, then release away from the sampling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_continued_stream();
		test_length_framing();
		test_blanks_and_trailing_text();
		test_malformed_length();
		test_saturation();
		test_ignored_keywords();
		test_odd_bytes();
		test_random_traffic();

		@(negedge clk);
		req.valid <= 1'b0;

		// drain outstanding results, then let the last result settle before the verdict
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
